@@ hdl/bpc_pkg.sv @@
package bpc_pkg;

   // Fixed field widths.
   localparam int LEVELS_W  = 2;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int EVENT_W   = 2;

   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [CFG_W-1:0]     cfg_type;
   typedef logic [EVENT_W-1:0]   event_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Item operations.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Latched event codes.
   localparam event_type EV_NONE   = 2'd0;
   localparam event_type EV_SHORT  = 2'd1;
   localparam event_type EV_LONG   = 2'd2;
   localparam event_type EV_DOUBLE = 2'd3;

   // Configuration register indexes.
   localparam csr_idx_type REG_DEBOUNCE   = 2'd0;
   localparam csr_idx_type REG_LONG_PRESS = 2'd1;
   localparam csr_idx_type REG_DOUBLE_GAP = 2'd2;

   // Configuration reset values.
   localparam cfg_type DEBOUNCE_RST   = 16'd5;
   localparam cfg_type LONG_PRESS_RST = 16'd100;
   localparam cfg_type DOUBLE_GAP_RST = 16'd30;

endpackage

@@ hdl/bpc_if.sv @@
// Tick or clear item channel.
interface bpc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [bpc_pkg::LEVELS_W-1:0]      button_levels;

   modport source (output valid, output op, output button_levels, input ready);
   modport sink   (input valid, input op, input button_levels, output ready);
endinterface

// Result channel carrying the latched event.
interface bpc_rsp_if;
   logic                   valid;
   logic                   ready;
   bpc_pkg::event_type     event_res;

   modport source (output valid, output event_res, input ready);
   modport sink   (input valid, input event_res, output ready);
endinterface

// Configuration write channel.
interface bpc_csr_if;
   logic                    valid;
   logic                    ready;
   bpc_pkg::csr_idx_type    index;
   bpc_pkg::cfg_type        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/button_press_classifier.sv @@
// Debounced button classifier. Every accepted tick item advances a 32-bit tick count,
// samples the active-low button pins (button 0 first) and classifies each debounced
// release as a short, long or double press; the first such event is latched until a
// clear item arrives. Each item produces one result carrying the latched event. The block
// takes one item per cycle while its skid stage is empty: all per-button compares run
// in the cycle of the transfer and the result is registered, backed by a one-entry skid
// stage, so one more item is accepted while a result waits to be taken. Configuration
// writes are accepted in every cycle and should only be issued while the block is idle.
module button_press_classifier #(
   parameter int NUM_BUTTONS = 2
) (
   input  logic             clock,
   input  logic             reset,
   bpc_req_if.sink          req_if,
   bpc_rsp_if.source        rsp_if,
   bpc_csr_if.sink          csr_if
);

   // Configuration registers.
   bpc_pkg::cfg_type debounce_ff, long_press_ff, double_gap_ff;

   // Timing and button state.
   bpc_pkg::time_type  tick_count_ff, tick_count_in;
   logic               pressed_ff    [NUM_BUTTONS];
   logic               pressed_in    [NUM_BUTTONS];
   bpc_pkg::time_type  press_start_ff [NUM_BUTTONS];
   bpc_pkg::time_type  press_start_in [NUM_BUTTONS];
   bpc_pkg::time_type  last_change_ff [NUM_BUTTONS];
   bpc_pkg::time_type  last_change_in [NUM_BUTTONS];
   bpc_pkg::time_type  last_release_ff [NUM_BUTTONS];
   bpc_pkg::time_type  last_release_in [NUM_BUTTONS];
   logic               seen_ff       [NUM_BUTTONS];
   logic               seen_in       [NUM_BUTTONS];
   bpc_pkg::event_type held_event_ff, held_event_in;
   logic               event_taken_ff, event_taken_in;

   // Result register and skid stage.
   bpc_pkg::event_type head_ff, skid_ff;
   logic               head_valid_ff, skid_valid_ff;

   logic req_xfer;
   logic rsp_xfer;
   logic [NUM_BUTTONS+bpc_pkg::LEVELS_W-1:0] levels_ext;

   assign req_if.ready     = !skid_valid_ff;
   assign req_xfer         = req_if.valid && req_if.ready;
   assign rsp_xfer         = head_valid_ff && rsp_if.ready;
   assign rsp_if.valid     = head_valid_ff;
   assign rsp_if.event_res = head_ff;
   assign csr_if.ready     = 1'b1;

   // Buttons beyond the pin field read as pressed (level zero).
   assign levels_ext = {{NUM_BUTTONS{1'b0}}, req_if.button_levels};

   // Configuration register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bpc_pkg::DEBOUNCE_RST;
         long_press_ff <= bpc_pkg::LONG_PRESS_RST;
         double_gap_ff <= bpc_pkg::DOUBLE_GAP_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            bpc_pkg::REG_DEBOUNCE:   debounce_ff   <= csr_if.data;
            bpc_pkg::REG_LONG_PRESS: long_press_ff <= csr_if.data;
            bpc_pkg::REG_DOUBLE_GAP: double_gap_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Per-item update: debounce, press timing and release classification.
   always_comb begin
      bpc_pkg::time_type  now;
      bpc_pkg::time_type  held;
      bpc_pkg::time_type  since;
      bpc_pkg::event_type ev;
      logic               pressed;

      now            = tick_count_ff + 1'b1;
      tick_count_in  = tick_count_ff;
      held_event_in  = held_event_ff;
      event_taken_in = event_taken_ff;
      held           = '0;
      since          = '0;
      ev             = bpc_pkg::EV_NONE;
      pressed        = 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         pressed_in[b]      = pressed_ff[b];
         press_start_in[b]  = press_start_ff[b];
         last_change_in[b]  = last_change_ff[b];
         last_release_in[b] = last_release_ff[b];
         seen_in[b]         = seen_ff[b];
      end

      if (req_xfer) begin
         if (req_if.op == bpc_pkg::OP_CLEAR) begin
            held_event_in  = bpc_pkg::EV_NONE;
            event_taken_in = 1'b1;
         end else begin
            tick_count_in = now;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
               pressed = !levels_ext[b];
               // A change counts only once the debounce window has expired.
               if ((now - last_change_ff[b]) >= {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}},
                                                 debounce_ff} &&
                   pressed != pressed_ff[b]) begin
                  last_change_in[b] = now;
                  pressed_in[b]     = pressed;
                  if (pressed) begin
                     press_start_in[b] = now;
                  end else begin
                     held  = now - press_start_ff[b];
                     since = now - last_release_ff[b];
                     if (since < {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, double_gap_ff} &&
                         seen_ff[b]) begin
                        ev         = bpc_pkg::EV_DOUBLE;
                        seen_in[b] = 1'b0;
                     end else begin
                        seen_in[b]         = 1'b1;
                        last_release_in[b] = now;
                        if (held >= {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, long_press_ff})
                        begin
                           ev = bpc_pkg::EV_LONG;
                        end else begin
                           ev = bpc_pkg::EV_SHORT;
                        end
                     end
                     // Only the lowest-numbered release latches, and only when free.
                     if (event_taken_in) begin
                        held_event_in  = ev;
                        event_taken_in = 1'b0;
                     end
                  end
               end
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         held_event_ff  <= bpc_pkg::EV_NONE;
         event_taken_ff <= 1'b1;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            pressed_ff[b]      <= 1'b0;
            press_start_ff[b]  <= '0;
            last_change_ff[b]  <= '0;
            last_release_ff[b] <= '0;
            seen_ff[b]         <= 1'b0;
         end
      end else begin
         tick_count_ff  <= tick_count_in;
         held_event_ff  <= held_event_in;
         event_taken_ff <= event_taken_in;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            pressed_ff[b]      <= pressed_in[b];
            press_start_ff[b]  <= press_start_in[b];
            last_change_ff[b]  <= last_change_in[b];
            last_release_ff[b] <= last_release_in[b];
            seen_ff[b]         <= seen_in[b];
         end
      end
   end

   // Result register with a one-entry skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_xfer) begin
            head_valid_ff <= skid_valid_ff || req_xfer;
            skid_valid_ff <= 1'b0;
         end else if (req_xfer) begin
            if (head_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               head_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         head_ff <= skid_valid_ff ? skid_ff : held_event_in;
      end else if (req_xfer) begin
         if (head_valid_ff) begin
            skid_ff <= held_event_in;
         end else begin
            head_ff <= held_event_in;
         end
      end
   end

   // The skid stage only fills behind a waiting result.
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry valid without a result in the head register");

   // A held event and the taken flag always agree.
   a_event_flag: assert property (@(posedge clock) disable iff (reset)
      (held_event_ff == bpc_pkg::EV_NONE) == event_taken_ff)
      else $error("latched event and taken flag disagree");

   // A clear transfer leaves no event latched.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_if.op == bpc_pkg::OP_CLEAR) |=>
         (event_taken_ff && held_event_ff == bpc_pkg::EV_NONE))
      else $error("clear transfer did not release the latched event");

   // The tick count moves only on a tick transfer.
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_xfer && req_if.op == bpc_pkg::OP_TICK) |=> $stable(tick_count_ff))
      else $error("tick count changed without a tick transfer");

endmodule
